// File: hw/rtl/kct_pkg.sv
// Shared types, codes and defaults of the keyed counter table.
package kct_pkg;

   localparam int ENTRIES_DEF  = 16;
   localparam int TAG_BITS_DEF = 16;

   localparam int KIND_W   = 2;
   localparam int TAG_W    = 16;
   localparam int AMOUNT_W = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 31;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SET    = 2'd2;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

   localparam logic [STATUS_W-1:0] ST_CHANGED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

   typedef enum logic [2:0] {
      ST_WIPE,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_EXEC
   } kct_state_type;

   typedef struct packed {
      logic wipe;
      logic load;
      logic scan;
      logic exec;
   } kct_cmd_type;

   typedef struct packed {
      logic last;
   } kct_stat_type;

endpackage

// File: hw/rtl/keyed_counter_table_top.sv
// Keyed counter table: a small associative table of tags with positive counts.
//
// A request (kind, tag, amount) is taken on a rising edge where start is high
// and busy is low. Kinds are add, remove, set and clear. Every request gives
// exactly one result: status, tag, and the count before and after.
// Each request scans the whole table through the RAM read port, one entry per
// cycle, then writes back one entry. Busy stays high from the transfer through
// the write-back cycle, so the block takes one request at a time.
// The result appears one cycle after the write-back
// cycle, marked by rsp_strobe for exactly one cycle, and busy drops in that
// same cycle so the next request may be taken while the result is shown.
// The receiver cannot stall; a result is transferred in its strobe cycle.
// After reset the block holds busy high while it clears the valid flag of
// every table entry.
module keyed_counter_table_top #(
   parameter int ENTRIES  = kct_pkg::ENTRIES_DEF,
   parameter int TAG_BITS = kct_pkg::TAG_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [kct_pkg::KIND_W-1:0]           req_kind,
   input  logic [kct_pkg::TAG_W-1:0]            req_tag,
   input  logic signed [kct_pkg::AMOUNT_W-1:0]  req_amount,
   output logic                                 rsp_strobe,
   output logic [kct_pkg::STATUS_W-1:0]         rsp_status,
   output logic [kct_pkg::TAG_W-1:0]            rsp_result_tag,
   output logic [kct_pkg::COUNT_W-1:0]          rsp_old_count,
   output logic [kct_pkg::COUNT_W-1:0]          rsp_new_count
);
   import kct_pkg::*;

   kct_cmd_type  cmd;
   kct_stat_type stat;

   kct_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .stat (stat),
      .cmd  (cmd),
      .busy (busy)
   );

   kct_datapath #(
      .ENTRIES (ENTRIES),
      .TAG_BITS(TAG_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_kind      (req_kind),
      .req_tag       (req_tag),
      .req_amount    (AMOUNT_W'(unsigned'(req_amount))),
      .rsp_strobe    (rsp_strobe),
      .rsp_status    (rsp_status),
      .rsp_result_tag(rsp_result_tag),
      .rsp_old_count (rsp_old_count),
      .rsp_new_count (rsp_new_count)
   );

endmodule

// File: hw/rtl/kct_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kct_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/kct_ctrl.sv
// Controller state machine of the keyed counter table.
module kct_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  kct_pkg::kct_stat_type stat,
   output kct_pkg::kct_cmd_type  cmd,
   output logic                 busy
);
   import kct_pkg::*;

   kct_state_type state_ff;
   kct_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_WIPE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         ST_WIPE: begin
            cmd.wipe = 1'b1;
            if (stat.last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_accept_scans: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == ST_SCAN))
      else $error("accepted request did not start a scan");

   a_drain_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |=> (state_ff == ST_EXEC))
      else $error("drain not followed by execute");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.wipe, cmd.load, cmd.scan, cmd.exec}))
      else $error("more than one datapath command at once");

endmodule

// File: hw/rtl/kct_datapath.sv
// Datapath of the keyed counter table: table RAM, scan and update logic.
module kct_datapath #(
   parameter int ENTRIES  = kct_pkg::ENTRIES_DEF,
   parameter int TAG_BITS = kct_pkg::TAG_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  kct_pkg::kct_cmd_type          cmd,
   output kct_pkg::kct_stat_type         stat,
   input  logic [kct_pkg::KIND_W-1:0]    req_kind,
   input  logic [kct_pkg::TAG_W-1:0]     req_tag,
   input  logic [kct_pkg::AMOUNT_W-1:0]  req_amount,
   output logic                          rsp_strobe,
   output logic [kct_pkg::STATUS_W-1:0]  rsp_status,
   output logic [kct_pkg::TAG_W-1:0]     rsp_result_tag,
   output logic [kct_pkg::COUNT_W-1:0]   rsp_old_count,
   output logic [kct_pkg::COUNT_W-1:0]   rsp_new_count
);
   import kct_pkg::*;

   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int KEY_W  = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
   localparam int WORD_W = 1 + KEY_W + COUNT_W;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

   logic [KIND_W-1:0]   kind_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [AMOUNT_W-1:0] amount_ff;

   logic [IDX_W-1:0]    scan_idx_ff;
   logic [IDX_W-1:0]    scan_idx_in;
   logic                chk_en_ff;
   logic [IDX_W-1:0]    chk_idx_ff;

   logic                match_ff;
   logic [IDX_W-1:0]    match_idx_ff;
   logic [COUNT_W-1:0]  match_count_ff;
   logic                free_ff;
   logic [IDX_W-1:0]    free_idx_ff;

   logic                rsp_strobe_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [TAG_W-1:0]    rsp_tag_ff;
   logic [COUNT_W-1:0]  rsp_old_ff;
   logic [COUNT_W-1:0]  rsp_new_ff;

   logic [WORD_W-1:0]   rd_word;
   logic                rd_valid;
   logic [KEY_W-1:0]    rd_key;
   logic [COUNT_W-1:0]  rd_count;

   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic [WORD_W-1:0]   wr_data;

   logic                positive;
   logic                active;
   logic [COUNT_W-1:0]  amt;
   logic [COUNT_W:0]    sum;
   logic [COUNT_W-1:0]  sat_sum;
   logic                upd_en;
   logic [IDX_W-1:0]    upd_idx;
   logic [WORD_W-1:0]   upd_word;
   logic [STATUS_W-1:0] res_status;
   logic [COUNT_W-1:0]  res_old;
   logic [COUNT_W-1:0]  res_new;

   assign stat.last = (scan_idx_ff == IDX_LAST);

   always_comb begin
      scan_idx_in = scan_idx_ff;
      if (cmd.load) begin
         scan_idx_in = '0;
      end else if (cmd.wipe || cmd.scan) begin
         scan_idx_in = stat.last ? '0 : scan_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff   <= '0;
         chk_en_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         scan_idx_ff   <= scan_idx_in;
         chk_en_ff     <= cmd.scan;
         rsp_strobe_ff <= cmd.exec;
      end
   end

   assign rd_valid = rd_word[WORD_W-1];
   assign rd_key   = rd_word[COUNT_W +: KEY_W];
   assign rd_count = rd_word[COUNT_W-1:0];

   always_ff @(posedge clock) begin
      chk_idx_ff <= scan_idx_ff;
      if (cmd.load) begin
         kind_ff   <= req_kind;
         key_ff    <= req_tag[KEY_W-1:0];
         amount_ff <= req_amount;
         match_ff  <= 1'b0;
         free_ff   <= 1'b0;
      end else if (chk_en_ff) begin
         if (rd_valid && (rd_key == key_ff) && !match_ff) begin
            match_ff       <= 1'b1;
            match_idx_ff   <= chk_idx_ff;
            match_count_ff <= rd_count;
         end
         if (!rd_valid && !free_ff) begin
            free_ff     <= 1'b1;
            free_idx_ff <= chk_idx_ff;
         end
      end
   end

   assign positive = (amount_ff != '0) && !amount_ff[AMOUNT_W-1];
   assign active   = (key_ff != '0) && (positive || (kind_ff == KIND_CLEAR));
   assign amt      = amount_ff[COUNT_W-1:0];
   assign sum      = {1'b0, match_count_ff} + {1'b0, amt};
   assign sat_sum  = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];

   always_comb begin
      upd_en     = 1'b0;
      upd_idx    = match_idx_ff;
      upd_word   = {1'b1, key_ff, amt};
      res_status = ST_IGNORED;
      res_old    = '0;
      res_new    = '0;
      if (active) begin
         case (kind_ff)
            KIND_ADD, KIND_SET: begin
               if (match_ff) begin
                  res_status = ST_CHANGED;
                  res_old    = match_count_ff;
                  res_new    = (kind_ff == KIND_ADD) ? sat_sum : amt;
                  upd_en     = 1'b1;
                  upd_word   = {1'b1, key_ff, res_new};
               end else if (free_ff) begin
                  res_status = ST_CHANGED;
                  res_new    = amt;
                  upd_en     = 1'b1;
                  upd_idx    = free_idx_ff;
               end else begin
                  res_status = ST_FULL;
               end
            end
            KIND_REMOVE, KIND_CLEAR: begin
               if (match_ff) begin
                  res_status = ST_CHANGED;
                  res_old    = match_count_ff;
                  upd_en     = 1'b1;
                  if ((kind_ff == KIND_CLEAR) || (match_count_ff <= amt)) begin
                     res_new  = '0;
                     upd_word = {1'b0, key_ff, match_count_ff};
                  end else begin
                     res_new  = match_count_ff - amt;
                     upd_word = {1'b1, key_ff, res_new};
                  end
               end
            end
            default: begin
               res_status = ST_IGNORED;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_status_ff <= res_status;
         rsp_tag_ff    <= TAG_W'(key_ff);
         rsp_old_ff    <= res_old;
         rsp_new_ff    <= res_new;
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = scan_idx_ff;
      wr_data = '0;
      if (cmd.wipe) begin
         wr_en = 1'b1;
      end else if (cmd.exec) begin
         wr_en   = upd_en;
         wr_addr = upd_idx;
         wr_data = upd_word;
      end
   end

   kct_ram #(
      .WIDTH (WORD_W),
      .DEPTH (ENTRIES),
      .ADDR_W(IDX_W)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(scan_idx_ff),
      .rd_data(rd_word)
   );

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_result_tag = rsp_tag_ff;
   assign rsp_old_count  = rsp_old_ff;
   assign rsp_new_count  = rsp_new_ff;

   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      scan_idx_ff <= IDX_LAST)
      else $error("scan index out of range");

   a_exec_strobe: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> rsp_strobe)
      else $error("execute did not produce a result");

   a_quiet_counts: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == ST_IGNORED || rsp_status == ST_FULL))
         |-> (rsp_old_count == '0 && rsp_new_count == '0))
      else $error("ignored or full result carries nonzero counts");

endmodule

// File: tb/keyed_counter_table_top_tb.sv
// Self-checking testbench for the keyed counter table: directed requests, then random traffic.
module keyed_counter_table_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import kct_pkg::*;

   localparam int SLOTS         = 16;
   localparam int RANDOM_ITEMS  = 750;
   localparam int POOL_SIZE     = 24;
   localparam int STALL_LIMIT   = 2000;
   localparam int DRAIN_CYCLES  = 40;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [TAG_W-1:0]    tag;
      logic [COUNT_W-1:0]  old_count;
      logic [COUNT_W-1:0]  new_count;
   } tally_update_type;

   typedef struct {
      logic [KIND_W-1:0]          kind;
      logic [TAG_W-1:0]           tag;
      logic signed [AMOUNT_W-1:0] amount;
      int                         reps;
      bit                         typed;
      tally_update_type           update;
   } directed_row_type;

   logic                        clock;
   logic                        reset      = 1'b1;
   logic                        start      = 1'b0;
   logic [KIND_W-1:0]           req_kind   = '0;
   logic [TAG_W-1:0]            req_tag    = '0;
   logic signed [AMOUNT_W-1:0]  req_amount = '0;
   logic                        busy;
   logic                        rsp_strobe;
   logic [STATUS_W-1:0]         rsp_status;
   logic [TAG_W-1:0]            rsp_result_tag;
   logic [COUNT_W-1:0]          rsp_old_count;
   logic [COUNT_W-1:0]          rsp_new_count;

   bit                 slot_used [SLOTS];
   logic [TAG_W-1:0]   slot_tag [SLOTS];
   logic [COUNT_W-1:0] slot_count [SLOTS];
   tally_update_type   pending_updates [$];
   logic [TAG_W-1:0]   tag_pool [POOL_SIZE];
   int                 mismatches = 0;
   int                 stall_cycles = 0;

   directed_row_type directed [18] = '{
      '{KIND_ADD,    16'h0000, 32'sd5,        1, 1'b1, '{ST_IGNORED, 16'h0000, '0, '0}},
      '{KIND_REMOVE, 16'h0007, 32'sd1,        1, 1'b1, '{ST_IGNORED, 16'h0007, '0, '0}},
      '{KIND_CLEAR,  16'h0007, 32'sd0,        1, 1'b1, '{ST_IGNORED, 16'h0007, '0, '0}},
      '{KIND_ADD,    16'h0001, 32'sd0,        1, 1'b1, '{ST_IGNORED, 16'h0001, '0, '0}},
      '{KIND_SET,    16'h0001, 32'h8000_0000, 1, 1'b1, '{ST_IGNORED, 16'h0001, '0, '0}},
      '{KIND_REMOVE, 16'h0001, -32'sd1,       1, 1'b1, '{ST_IGNORED, 16'h0001, '0, '0}},
      '{KIND_ADD,    16'hFFFF, 32'h7FFF_FFFF, 1, 1'b1,
        '{ST_CHANGED, 16'hFFFF, '0, COUNT_MAX}},
      '{KIND_ADD,    16'hFFFF, 32'sd1,        1, 1'b1,
        '{ST_CHANGED, 16'hFFFF, COUNT_MAX, COUNT_MAX}},
      '{KIND_SET,    16'hFFFF, 32'sd1,        1, 1'b1,
        '{ST_CHANGED, 16'hFFFF, COUNT_MAX, 31'd1}},
      '{KIND_REMOVE, 16'hFFFF, 32'h7FFF_FFFF, 1, 1'b1, '{ST_CHANGED, 16'hFFFF, 31'd1, '0}},
      '{KIND_SET,    16'h0002, 32'sd100,      1, 1'b1, '{ST_CHANGED, 16'h0002, '0, 31'd100}},
      '{KIND_REMOVE, 16'h0002, 32'sd30,       1, 1'b0, '{ST_CHANGED, 16'h0002, '0, '0}},
      '{KIND_CLEAR,  16'h0002, 32'h8000_0000, 1, 1'b0, '{ST_CHANGED, 16'h0002, '0, '0}},
      '{KIND_ADD,    16'h0010, 32'sd1,        SLOTS, 1'b0, '{ST_CHANGED, 16'h0000, '0, '0}},
      '{KIND_ADD,    16'h0200, 32'sd1,        1, 1'b1, '{ST_FULL, 16'h0200, '0, '0}},
      '{KIND_SET,    16'h0201, 32'sd5,        1, 1'b1, '{ST_FULL, 16'h0201, '0, '0}},
      '{KIND_CLEAR,  16'h0013, 32'sd0,        1, 1'b0, '{ST_CHANGED, 16'h0013, '0, '0}},
      '{KIND_ADD,    16'h0300, 32'sd9,        1, 1'b0, '{ST_CHANGED, 16'h0300, '0, '0}}
   };

   keyed_counter_table_top DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_tag        (req_tag),
      .req_amount     (req_amount),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_result_tag (rsp_result_tag),
      .rsp_old_count  (rsp_old_count),
      .rsp_new_count  (rsp_new_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic tally_update_type apply_request(logic [KIND_W-1:0] kind,
                                                      logic [TAG_W-1:0] tag,
                                                      logic signed [AMOUNT_W-1:0] amount);
      tally_update_type upd;
      int               hit;
      int               free_slot;
      logic [31:0]      sum;
      upd = '{ST_IGNORED, tag, '0, '0};
      hit = -1;
      free_slot = -1;
      if (tag != '0 && (amount > 0 || kind == KIND_CLEAR)) begin
         for (int i = 0; i < SLOTS; i++) begin
            if (hit < 0 && slot_used[i] && slot_tag[i] == tag) hit = i;
            if (free_slot < 0 && !slot_used[i]) free_slot = i;
         end
         if (kind == KIND_ADD || kind == KIND_SET) begin
            if (hit >= 0) begin
               upd.old_count = slot_count[hit];
               if (kind == KIND_ADD) begin
                  sum = {1'b0, slot_count[hit]} + {1'b0, amount[COUNT_W-1:0]};
                  upd.new_count = (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[COUNT_W-1:0];
               end else begin
                  upd.new_count = amount[COUNT_W-1:0];
               end
               slot_count[hit] = upd.new_count;
               upd.status = ST_CHANGED;
            end else if (free_slot >= 0) begin
               slot_used[free_slot] = 1'b1;
               slot_tag[free_slot] = tag;
               slot_count[free_slot] = amount[COUNT_W-1:0];
               upd.new_count = amount[COUNT_W-1:0];
               upd.status = ST_CHANGED;
            end else begin
               upd.status = ST_FULL;
            end
         end else if (hit >= 0) begin
            upd.old_count = slot_count[hit];
            if (kind == KIND_CLEAR || slot_count[hit] <= amount[COUNT_W-1:0]) begin
               slot_used[hit] = 1'b0;
               upd.new_count = '0;
            end else begin
               upd.new_count = slot_count[hit] - amount[COUNT_W-1:0];
               slot_count[hit] = upd.new_count;
            end
            upd.status = ST_CHANGED;
         end
      end
      return upd;
   endfunction

   task automatic transfer_request(input logic [KIND_W-1:0] kind,
                                   input logic [TAG_W-1:0] tag,
                                   input logic signed [AMOUNT_W-1:0] amount,
                                   input bit typed,
                                   input tally_update_type typed_update);
      tally_update_type predicted;
      start <= 1'b1;
      req_kind <= kind;
      req_tag <= tag;
      req_amount <= amount;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = apply_request(kind, tag, amount);
      pending_updates.push_back(typed ? typed_update : predicted);
   endtask

   task automatic maybe_pause(input bit allowed);
      if (allowed && $urandom_range(0, 99) < 17) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
   endtask

   function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s expected %0h actual %0h", $time, field, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      tally_update_type want;
      if (!reset && rsp_strobe) begin
         if (pending_updates.size() == 0) begin
            $display("%0t ns: unexpected result expected none actual tag %0h status %0h",
                     $time, rsp_result_tag, rsp_status);
            mismatches++;
         end else begin
            want = pending_updates.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_status));
            check_field("result_tag", 32'(want.tag), 32'(rsp_result_tag));
            check_field("old_count", 32'(want.old_count), 32'(rsp_old_count));
            check_field("new_count", 32'(want.new_count), 32'(rsp_new_count));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("keyed_counter_table_top_tb: errors");
         $finish;
      end
   end

   initial begin
      logic [KIND_W-1:0]          kind;
      logic [TAG_W-1:0]           tag;
      logic signed [AMOUNT_W-1:0] amount;
      int                         pick;
      bit                         fill_phase;
      foreach (tag_pool[i]) tag_pool[i] = TAG_W'($urandom_range(1, 16'hFFFF));
      tag_pool[0] = 16'hFFFF;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[r]) begin
         for (int k = 0; k < directed[r].reps; k++) begin
            maybe_pause(1'b1);
            transfer_request(directed[r].kind, TAG_W'(directed[r].tag + k), directed[r].amount,
                             directed[r].typed, directed[r].update);
         end
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         fill_phase = ((n / 60) % 2) == 0;
         pick = $urandom_range(0, 9);
         if (fill_phase) begin
            kind = (pick < 4) ? KIND_ADD : (pick < 7) ? KIND_SET :
                   (pick < 9) ? KIND_REMOVE : KIND_CLEAR;
         end else begin
            kind = (pick < 3) ? KIND_ADD : (pick < 4) ? KIND_SET :
                   (pick < 7) ? KIND_REMOVE : KIND_CLEAR;
         end
         pick = $urandom_range(0, 99);
         if (pick < 4) tag = '0;
         else if (pick < 12) tag = TAG_W'($urandom());
         else tag = tag_pool[$urandom_range(0, POOL_SIZE - 1)];
         pick = $urandom_range(0, 99);
         if (pick < 2) amount = '0;
         else if (pick < 4) amount = 32'h8000_0000;
         else if (pick < 8) amount = $urandom() | 32'h8000_0000;
         else if (pick < 14) amount = 32'h7FFF_FFFF - $urandom_range(0, 3);
         else if (pick < 30) amount = ($urandom() & 32'h7FFF_FFFF) | 32'h1;
         else amount = $urandom_range(1, 50);
         if (n == RANDOM_ITEMS / 2) begin
            start <= 1'b0;
            while (pending_updates.size() != 0) @(posedge clock);
            @(posedge clock);
         end else begin
            maybe_pause(n < 100 || n >= 300);
         end
         transfer_request(kind, tag, amount, 1'b0, '0);
      end

      start <= 1'b0;
      while (pending_updates.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("keyed_counter_table_top_tb: clean");
      end else begin
         $display("keyed_counter_table_top_tb: errors");
      end
      $finish;
   end

endmodule
